// ===== rtl/core/hfe_pkg.sv =====
`timescale 1ns / 1ps

package hfe_pkg;

	localparam logic [7:0] FlagByte = 8'h7E;
	localparam logic [7:0] EscByte = 8'h7D;
	localparam logic [7:0] EscXor = 8'h20;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'h8408;

	localparam int MaxResults = 8;
	localparam int IdxW = $clog2(MaxResults);
	localparam int CntW = IdxW + 1;
	localparam int CapW = 13;
	localparam logic [CapW-1:0] CapReset = 13'd4096;

	// Register index codes, taken from the word address.
	localparam logic [0:0] RegFrameCapacity = 1'b0;

	typedef struct packed {
		logic [7:0] data;
		logic present;
		logic fend;
		logic ovf;
	} hfe_entry_t;

	typedef struct packed {
		hfe_entry_t [MaxResults-1:0] ent;
		logic [CntW-1:0] cnt;
	} hfe_batch_t;

	typedef struct packed {
		hfe_batch_t batch;
		logic [3:0] used;
		logic ovf;
	} hfe_work_t;

	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

	// Appends one byte, escaped where asked, unless the frame has already overflowed or has no room left for it.
	function automatic hfe_work_t send_byte(hfe_work_t w, logic [7:0] b, logic stuff,
		logic fend, logic [3:0] room);
		hfe_work_t r;
		logic esc;
		logic [4:0] need_end;
		r = w;
		esc = stuff && (b == FlagByte || b == EscByte);
		need_end = {1'b0, w.used} + (esc ? 5'd2 : 5'd1);
		if (!w.ovf) begin
			if (need_end > {1'b0, room}) begin
				r.ovf = 1'b1;
			end else begin
				if (esc) begin
					r.batch.ent[r.batch.cnt[IdxW-1:0]] = '{EscByte, 1'b1, 1'b0, 1'b0};
					r.batch.cnt = r.batch.cnt + 1'b1;
					r.batch.ent[r.batch.cnt[IdxW-1:0]] = '{b ^ EscXor, 1'b1, 1'b0, 1'b0};
					r.batch.cnt = r.batch.cnt + 1'b1;
				end else begin
					r.batch.ent[r.batch.cnt[IdxW-1:0]] = '{b, 1'b1, fend, 1'b0};
					r.batch.cnt = r.batch.cnt + 1'b1;
				end
				r.used = need_end[3:0];
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/hfe_cfg_regs.sv =====
`timescale 1ns / 1ps

module hfe_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [hfe_pkg::CapW-1:0] capacity
);

	logic [hfe_pkg::CapW-1:0] capacity_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr[2] == hfe_pkg::RegFrameCapacity);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= hfe_pkg::CapReset;
		end else if (wr_en) begin
			capacity_q <= pwdata[hfe_pkg::CapW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			hfe_pkg::RegFrameCapacity: prdata = {{(32 - hfe_pkg::CapW){1'b0}}, capacity_q};
			default: prdata = '0;
		endcase
	end

	assign capacity = capacity_q;

endmodule

// ===== rtl/core/hfe_frame_builder.sv =====
`timescale 1ns / 1ps

module hfe_frame_builder (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] payload_byte,
	input  logic has_byte,
	input  logic end_of_payload,
	input  logic [hfe_pkg::CapW-1:0] limit,
	output logic batch_valid,
	output hfe_pkg::hfe_batch_t batch,
	input  logic batch_take
);

	logic vld_s1;
	logic [7:0] byte_s1;
	logic has_s1;
	logic eop_s1;

	logic [15:0] crc_q;
	logic [hfe_pkg::CapW-1:0] count_q;
	logic in_frame_q;
	logic ovf_q;

	logic active;
	logic [15:0] crc_new;
	logic [15:0] fcs;
	logic [hfe_pkg::CapW:0] diff;
	logic [3:0] room;
	hfe_pkg::hfe_work_t w;

	assign in_ready = !vld_s1 || batch_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= payload_byte;
			has_s1 <= has_byte;
			eop_s1 <= end_of_payload;
		end
	end

	// Room left in the frame, clipped: no item can need more than eight bytes.
	always_comb begin
		diff = {1'b0, limit} - {1'b0, count_q};
		if (count_q >= limit) begin
			room = 4'd0;
		end else if (diff > 14'd15) begin
			room = 4'd15;
		end else begin
			room = diff[3:0];
		end
	end

	always_comb begin
		active = has_s1 || eop_s1;
		crc_new = has_s1 ? hfe_pkg::crc_byte(crc_q, byte_s1) : crc_q;
		fcs = ~crc_new;
		w = '0;
		w.ovf = ovf_q;
		if (active && !in_frame_q) begin
			w = hfe_pkg::send_byte(w, hfe_pkg::FlagByte, 1'b0, 1'b0, room);
		end
		if (has_s1) begin
			w = hfe_pkg::send_byte(w, byte_s1, 1'b1, 1'b0, room);
		end
		if (eop_s1) begin
			w = hfe_pkg::send_byte(w, fcs[7:0], 1'b1, 1'b0, room);
			w = hfe_pkg::send_byte(w, fcs[15:8], 1'b1, 1'b0, room);
			w = hfe_pkg::send_byte(w, hfe_pkg::FlagByte, 1'b0, 1'b1, room);
			if (w.ovf) begin
				w.batch.ent[w.batch.cnt[hfe_pkg::IdxW-1:0]] = '{8'h00, 1'b0, 1'b1, 1'b1};
				w.batch.cnt = w.batch.cnt + 1'b1;
			end
		end
	end

	assign batch_valid = vld_s1;
	assign batch = w.batch;

	// A closing item returns the frame state to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= hfe_pkg::CrcInit;
			count_q <= '0;
			in_frame_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (batch_take) begin
			if (eop_s1) begin
				crc_q <= hfe_pkg::CrcInit;
				count_q <= '0;
				in_frame_q <= 1'b0;
				ovf_q <= 1'b0;
			end else if (has_s1) begin
				crc_q <= crc_new;
				count_q <= count_q + {{(hfe_pkg::CapW - 4){1'b0}}, w.used};
				in_frame_q <= 1'b1;
				ovf_q <= w.ovf;
			end
		end
	end

endmodule

// ===== rtl/core/hfe_result_buf.sv =====
`timescale 1ns / 1ps

module hfe_result_buf (
	input  logic clk,
	input  logic arst_n,
	input  logic batch_valid,
	input  hfe_pkg::hfe_batch_t batch,
	output logic batch_take,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic byte_present,
	output logic run_last,
	output logic frame_end,
	output logic overflow
);

	hfe_pkg::hfe_entry_t [hfe_pkg::MaxResults-1:0] ents_q;
	logic [hfe_pkg::CntW-1:0] cnt_q;
	logic [hfe_pkg::IdxW-1:0] idx_q;
	logic last;
	logic load_ok;
	hfe_pkg::hfe_entry_t cur;

	assign out_valid = (cnt_q != '0);
	assign last = ({1'b0, idx_q} == (cnt_q - 1'b1));
	// A new batch may load in the cycle the final result of the current one leaves.
	assign load_ok = !out_valid || (out_ready && last);
	assign batch_take = batch_valid && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (batch_take) begin
			cnt_q <= batch.cnt;
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			if (last) begin
				cnt_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (batch_take) begin
			ents_q <= batch.ent;
		end
	end

	assign cur = ents_q[idx_q];
	assign out_byte = cur.data;
	assign byte_present = cur.present;
	assign frame_end = cur.fend;
	assign overflow = cur.ovf;
	assign run_last = last;

endmodule

// ===== rtl/core/hdlc_frame_encoder_crc16_unit.sv =====
`timescale 1ns / 1ps

// HDLC-like frame encoder with a CRC-16/X.25 trailer. Each input item is taken into an input
// register; the frame bytes it causes (opening flag, escaped data byte, escaped checksum
// bytes, closing flag or overflow report, up to eight in all) are built from that register
// and leave the result buffer one per cycle while out_ready is high. An item yields one or
// two results per payload byte in mid-frame, and up to eight on the final item. An item
// that yields no result, such as an idle item, still passes through the input register.
// The output buffer sets the rate, and the next item waits in the input register while
// results are still being taken. frame_capacity sits at byte address 0 and resets to 4096;
// the limit in force is its minimum with MAX_FRAME_BYTES.
module hdlc_frame_encoder_crc16_unit #(
	parameter int unsigned MAX_FRAME_BYTES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] payload_byte,
	input  logic has_byte,
	input  logic end_of_payload,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic byte_present,
	output logic run_last,
	output logic frame_end,
	output logic overflow
);

	localparam logic [16:0] MaxBytes = 17'(MAX_FRAME_BYTES);

	logic [hfe_pkg::CapW-1:0] capacity;
	logic [hfe_pkg::CapW-1:0] limit;
	logic batch_valid;
	logic batch_take;
	hfe_pkg::hfe_batch_t batch;

	hfe_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.capacity(capacity)
	);

	assign limit = ({4'b0000, capacity} > MaxBytes) ? MaxBytes[hfe_pkg::CapW-1:0] : capacity;

	hfe_frame_builder u_build (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.payload_byte(payload_byte),
		.has_byte(has_byte),
		.end_of_payload(end_of_payload),
		.limit(limit),
		.batch_valid(batch_valid),
		.batch(batch),
		.batch_take(batch_take)
	);

	hfe_result_buf u_buf (
		.clk(clk),
		.arst_n(arst_n),
		.batch_valid(batch_valid),
		.batch(batch),
		.batch_take(batch_take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_present(byte_present),
		.run_last(run_last),
		.frame_end(frame_end),
		.overflow(overflow)
	);

endmodule
